// ===== sv/shtr_pkg.sv =====
// ----------------------------------------------------------------------------
// shtr_pkg
// Types, constants and a helper function shared by the truncated SHA-256 unit.
// ----------------------------------------------------------------------------
package shtr_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD
    } back_state_t;

    localparam logic       FUNC_ABSORB = 1'b0;
    localparam logic       FUNC_FINISH = 1'b1;
    localparam logic [7:0] PAD_BYTE    = 8'h80;

    localparam logic [31:0] INIT_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // All ones at 64 or more, otherwise the low bits set.
    function automatic logic [63:0] low_mask(input logic [7:0] bits);
        logic [63:0] m;
        begin
            if (bits >= 8'd64)
            begin
                m = '1;
            end
            else
            begin
                m = (64'd1 << bits[5:0]) - 64'd1;
            end
            return m;
        end
    endfunction

endpackage

// ===== sv/shtr_front.sv =====
// ----------------------------------------------------------------------------
// shtr_front
// Input stage: accepts transactions and holds them in a short queue.
// ----------------------------------------------------------------------------
module shtr_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            func,
    input  logic [7:0]      data_byte,
    output logic            q_valid,
    output shtr_pkg::item_t q_item,
    input  logic            q_pop
);

    shtr_pkg::item_t                  mem_reg [shtr_pkg::QUEUE_DEPTH];
    logic [shtr_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [shtr_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [shtr_pkg::QUEUE_AW:0]      count_reg, count_next;
    logic                             push;
    logic                             pop;

    assign in_stall = (count_reg == (shtr_pkg::QUEUE_AW+1)'(shtr_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{func: func, data_byte: data_byte};
        end
    end

endmodule

// ===== sv/shtr_back.sv =====
// ----------------------------------------------------------------------------
// shtr_back
// Execution stage: packs bytes, runs the compression rounds, emits digests.
// ----------------------------------------------------------------------------
module shtr_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  shtr_pkg::item_t q_item,
    output logic            q_pop,
    input  logic [7:0]      digest_bits,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [63:0]     digest_low,
    output logic [63:0]     digest_high
);

    shtr_pkg::back_state_t state_reg, state_next;

    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] sum [8];
    logic [5:0]  cnt_reg, cnt_next;
    logic [5:0]  round_reg, round_next;
    logic        fin_reg, fin_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] hi_reg, hi_next;

    logic [31:0] s0, s1, sig0, sig1, ch, maj, t1, t2, w_new;
    logic        out_free;
    logic        take;
    logic [63:0] lo_raw, hi_raw;
    logic [7:0]  bits_m64;

    assign out_valid   = out_valid_reg;
    assign digest_low  = lo_reg;
    assign digest_high = hi_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    assign take        = (state_reg == shtr_pkg::ST_IDLE) && q_valid;
    assign q_pop       = take;

    // Round function and message schedule on the sliding window, plus chaining sums and digest words.
    always_comb
    begin
        sig1  = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
              ^ {v_reg[4][24:0], v_reg[4][31:25]};
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + sig1 + ch + shtr_pkg::ROUND_K[round_reg] + w_reg[0];
        sig0  = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
              ^ {v_reg[0][21:0], v_reg[0][31:22]};
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = sig0 + maj;
        s0    = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
              ^ (w_reg[1] >> 3);
        s1    = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
              ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        for (int i = 0; i < 8; i++)
        begin
            sum[i] = h_reg[i] + v_reg[i];
        end
        lo_raw   = {sum[1], sum[0]};
        hi_raw   = {sum[3], sum[2]};
        bits_m64 = digest_bits - 8'd64;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            shtr_pkg::ST_IDLE:
            begin
                if (take && (q_item.func == shtr_pkg::FUNC_FINISH || cnt_reg == 6'd63))
                begin
                    state_next = shtr_pkg::ST_ROUND;
                end
            end
            shtr_pkg::ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = shtr_pkg::ST_ADD;
                end
            end
            shtr_pkg::ST_ADD:
            begin
                if (!fin_reg || out_free)
                begin
                    state_next = shtr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = shtr_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        w_next         = w_reg;
        h_next         = h_reg;
        v_next         = v_reg;
        cnt_next       = cnt_reg;
        round_next     = round_reg;
        fin_next       = fin_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            shtr_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    round_next = '0;
                    v_next     = h_reg;
                    if (q_item.func == shtr_pkg::FUNC_ABSORB)
                    begin
                        w_next[cnt_reg[5:2]][8*(3-cnt_reg[1:0]) +: 8] = q_item.data_byte;
                        cnt_next = cnt_reg + 6'd1;
                        fin_next = 1'b0;
                    end
                    else
                    begin
                        // Keep bytes already held, mark the end, clear the rest.
                        for (int j = 0; j < 64; j++)
                        begin
                            if (6'(j) == cnt_reg)
                            begin
                                w_next[j/4][8*(3-(j%4)) +: 8] = shtr_pkg::PAD_BYTE;
                            end
                            else if (6'(j) > cnt_reg)
                            begin
                                w_next[j/4][8*(3-(j%4)) +: 8] = 8'h00;
                            end
                        end
                        fin_next = 1'b1;
                        cnt_next = '0;
                    end
                end
            end
            shtr_pkg::ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = w_new;
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                round_next = round_reg + 6'd1;
            end
            shtr_pkg::ST_ADD:
            begin
                if (!fin_reg)
                begin
                    h_next = sum;
                end
                else if (out_free)
                begin
                    h_next         = shtr_pkg::INIT_WORDS;
                    out_valid_next = 1'b1;
                    if (digest_bits < 8'd64)
                    begin
                        lo_next = lo_raw & shtr_pkg::low_mask(digest_bits);
                        hi_next = '0;
                    end
                    else
                    begin
                        lo_next = lo_raw;
                        hi_next = (digest_bits >= 8'd128) ? hi_raw
                                : (hi_raw & shtr_pkg::low_mask(bits_m64));
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shtr_pkg::ST_IDLE;
            cnt_reg       <= '0;
            round_reg     <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            h_reg         <= shtr_pkg::INIT_WORDS;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            round_reg     <= round_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg  <= w_next;
        v_reg  <= v_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

endmodule

// ===== sv/sha256_truncated_stream_hash_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_truncated_stream_hash_unit
// Byte-stream SHA-256 with 0x80-then-zero padding (no length field) and a digest truncated to at most 128 bits.
// ----------------------------------------------------------------------------
// Flow: a byte waits in the input queue until the engine is idle and takes it;
// the 64th byte of a block or a finish transaction starts the round loop
// (ST_ROUND), then ST_ADD adds into the chaining words or, for a finish,
// registers the digest once the output is free. The engine takes no byte meanwhile.
// Throughput: one byte per cycle within a block while the engine is idle.
// Reset: chaining words to the initial values, byte count zero, digest_bits 128.
module sha256_truncated_stream_hash_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_low,
    output logic [63:0] digest_high,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]      digest_bits_reg;
    logic            q_valid;
    logic            q_pop;
    shtr_pkg::item_t q_item;

    // The only register spans the whole address range.
    assign pready = 1'b1;
    assign prdata = {24'd0, digest_bits_reg} | {30'd0, paddr & 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_bits_reg <= 8'd128;
        end
        else if (psel && penable && pwrite)
        begin
            digest_bits_reg <= pwdata[7:0];
        end
    end

    shtr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .data_byte (data_byte),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    shtr_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .digest_bits (digest_bits_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_low  (digest_low),
        .digest_high (digest_high)
    );

endmodule
